// ===== hdl/mfl_pkg.sv =====
package mfl_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int FIR_TAPS_DEF = 17;
  localparam int LMS_TAPS_DEF = 16;

  localparam int CH_W       = 3;
  localparam int SMP_W      = 16;
  localparam int PWR_W      = 32;
  localparam int ACT_W      = 4;
  localparam int MU_W       = 16;
  localparam int WGT_W      = 24;
  localparam int TAP_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 16;
  localparam int S_TUSER_W  = 3;
  localparam int M_TDATA_W  = 48;
  localparam int M_TUSER_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;

  localparam logic             ENABLE_RST = 1'b1;
  localparam logic [ACT_W-1:0] ACTIVE_RST = 4'd8;
  localparam logic [MU_W-1:0]  STEP_RST   = 16'd655;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_FIR = 3'd0;
  localparam logic [OP_W-1:0] OP_LMS = 3'd1;
  localparam logic [OP_W-1:0] OP_MUE = 3'd2;
  localparam logic [OP_W-1:0] OP_UPD = 3'd3;
  localparam logic [OP_W-1:0] OP_YY  = 3'd4;
  localparam logic [OP_W-1:0] OP_PW  = 3'd5;

  localparam logic [24:0] PWR_KEEP = 25'd65470;

  typedef struct packed {
    logic             accept;
    logic             issue;
    logic [OP_W-1:0]  op;
    logic [TAP_W-1:0] k;
    logic             finx;
    logic             finy;
    logic             finish;
  } mfl_cmd_t;

  typedef struct packed {
    logic skip;
    logic out_block;
  } mfl_sts_t;

  function automatic logic signed [15:0] lp_coef(input logic [TAP_W-1:0] k);
    logic signed [15:0] c;
    case (k)
      6'd0, 6'd16:  c = 16'sd31;
      6'd1, 6'd15:  c = 16'sd62;
      6'd2, 6'd14:  c = 16'sd124;
      6'd3, 6'd13:  c = 16'sd247;
      6'd4, 6'd12:  c = 16'sd495;
      6'd5, 6'd11:  c = 16'sd990;
      6'd6, 6'd10:  c = 16'sd1980;
      6'd7, 6'd9:   c = 16'sd3959;
      6'd8:         c = 16'sd7919;
      default:      c = 16'sd0;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/mfl_ram.sv =====
module mfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mfl_ctrl.sv =====
module mfl_ctrl #(
  parameter int FIR_TAPS = mfl_pkg::FIR_TAPS_DEF,
  parameter int LMS_TAPS = mfl_pkg::LMS_TAPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mfl_pkg::mfl_sts_t  sts_i,
  output mfl_pkg::mfl_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIR   = 4'd1;
  localparam logic [3:0] S_FINX  = 4'd2;
  localparam logic [3:0] S_LMS   = 4'd3;
  localparam logic [3:0] S_FINY  = 4'd4;
  localparam logic [3:0] S_MUE   = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_PW    = 4'd7;
  localparam logic [3:0] S_DRAIN = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic [mfl_pkg::TAP_W-1:0] FIR_LAST = mfl_pkg::TAP_W'(FIR_TAPS - 1);
  localparam logic [mfl_pkg::TAP_W-1:0] LMS_LAST = mfl_pkg::TAP_W'(LMS_TAPS - 1);

  logic [3:0]                state_q, state_d, ret_q, ret_d;
  logic [mfl_pkg::TAP_W-1:0] k_q, k_d;
  logic                      dcnt_q, dcnt_d;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    k_d        = k_q;
    dcnt_d     = dcnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.k    = k_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          k_d          = '0;
          state_d      = sts_i.skip ? S_OUT : S_FIR;
        end
      end
      S_FIR: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = mfl_pkg::OP_FIR;
        if (k_q == FIR_LAST) begin
          state_d = S_DRAIN;
          ret_d   = S_FINX;
          dcnt_d  = 1'b0;
          k_d     = '0;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_FINX: begin
        cmd_o.finx = 1'b1;
        state_d    = S_LMS;
      end
      S_LMS: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = mfl_pkg::OP_LMS;
        if (k_q == LMS_LAST) begin
          state_d = S_DRAIN;
          ret_d   = S_FINY;
          dcnt_d  = 1'b0;
          k_d     = '0;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_FINY: begin
        cmd_o.finy = 1'b1;
        state_d    = S_MUE;
      end
      S_MUE: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = mfl_pkg::OP_MUE;
        state_d     = S_DRAIN;
        ret_d       = S_UPD;
        dcnt_d      = 1'b0;
      end
      S_UPD: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = mfl_pkg::OP_UPD;
        if (k_q == LMS_LAST) begin
          state_d = S_DRAIN;
          ret_d   = S_PW;
          dcnt_d  = 1'b0;
          k_d     = '0;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_PW: begin
        cmd_o.issue = 1'b1;
        if (k_q == '0) begin
          cmd_o.op = mfl_pkg::OP_YY;
          k_d      = k_q + 1'b1;
        end else begin
          cmd_o.op = mfl_pkg::OP_PW;
          state_d  = S_DRAIN;
          ret_d    = S_OUT;
          dcnt_d   = 1'b0;
          k_d      = '0;
        end
      end
      S_DRAIN: begin
        if (dcnt_q) begin
          state_d = ret_q;
        end else begin
          dcnt_d = 1'b1;
        end
      end
      S_OUT: begin
        if (!sts_i.out_block) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      k_q     <= '0;
      dcnt_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      k_q     <= k_d;
      dcnt_q  <= dcnt_d;
    end
  end

endmodule

// ===== hdl/mfl_dp.sv =====
module mfl_dp #(
  parameter int CHANNELS = mfl_pkg::CHANNELS_DEF,
  parameter int FIR_TAPS = mfl_pkg::FIR_TAPS_DEF,
  parameter int LMS_TAPS = mfl_pkg::LMS_TAPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mfl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mfl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [mfl_pkg::CH_W-1:0]       in_ch_i,
  input  logic [mfl_pkg::SMP_W-1:0]      in_raw_i,
  input  mfl_pkg::mfl_cmd_t              cmd_i,
  output mfl_pkg::mfl_sts_t              sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mfl_pkg::SMP_W-1:0]      out_filt_o,
  output logic [mfl_pkg::PWR_W-1:0]      out_pwr_o,
  output logic                           out_status_o
);

  localparam int CHI = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FHW = (FIR_TAPS > 1) ? $clog2(FIR_TAPS) : 1;
  localparam int LHW = (LMS_TAPS > 1) ? $clog2(LMS_TAPS) : 1;
  localparam int FD  = CHANNELS * FIR_TAPS;
  localparam int LD  = CHANNELS * LMS_TAPS;
  localparam int FAW = (FD > 1) ? $clog2(FD) : 1;
  localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
  localparam int ACCW = 48;
  localparam int TW  = mfl_pkg::TAP_W;

  logic                    en_q;
  logic [mfl_pkg::ACT_W-1:0] act_q;
  logic [mfl_pkg::MU_W-1:0]  mu_q;

  logic [CHI-1:0]     ch_q, ch_in;
  logic signed [15:0] raw_q;
  logic               rej_q, byp_q, rej_in;

  logic [FHW-1:0] fhd_q [CHANNELS];
  logic [LHW-1:0] lhd_q [CHANNELS];
  logic [mfl_pkg::PWR_W-1:0] pwr_q [CHANNELS];
  logic [CHANNELS-1:0] ffull_q, lfull_q, wdone_q;

  logic signed [ACCW-1:0] acc_q;
  logic signed [15:0]     x_q, y_q;
  logic signed [32:0]     mue_q;
  logic [30:0]            yy_q;

  logic [FHW-1:0] fhd_cur, fhd_in;
  logic [LHW-1:0] lhd_cur;
  logic [TW:0]    fsum, lsum;
  logic [FHW-1:0] fidx;
  logic [LHW-1:0] lidx;

  logic           fir_we;
  logic [FAW-1:0] fir_waddr, fir_raddr;
  logic [15:0]    fir_rdata;
  logic           lh_we;
  logic [LAW-1:0] lh_waddr, lh_raddr;
  logic [15:0]    lh_rdata;
  logic           w_we;
  logic [LAW-1:0] w_waddr, w_raddr;
  logic [23:0]    w_rdata, w_wdata;

  logic                  iss1_q, iss2_q;
  logic [mfl_pkg::OP_W-1:0] op1_q, op2_q;
  logic [TW-1:0]         k1_q, k2_q;
  logic signed [15:0]    coef1_q;
  logic                  fv1_q, lv1_q, wv1_q;
  logic signed [15:0]    fir_d, u_d;
  logic signed [23:0]    w_d, w2_q;
  logic signed [32:0]    ma;
  logic signed [24:0]    mb;
  logic signed [57:0]    prod_d, prod_q;

  logic signed [16:0]    e;
  logic signed [ACCW-1:0] rx, ry;
  logic signed [15:0]    x_new, y_new;
  logic signed [57:0]    upd;
  logic signed [25:0]    wsum;
  logic [49:0]           psum;
  logic [mfl_pkg::PWR_W-1:0] pnew;

  logic out_valid_q;
  logic [mfl_pkg::SMP_W-1:0] filt_q;
  logic [mfl_pkg::PWR_W-1:0] opwr_q;
  logic stat_q;

  assign ch_in   = CHI'(in_ch_i);
  assign rej_in  = ({1'b0, in_ch_i} >= act_q) || (int'(in_ch_i) >= CHANNELS);
  assign sts_o.skip      = rej_in || !en_q;
  assign sts_o.out_block = out_valid_q && !out_ready_i;

  assign fhd_in  = fhd_q[ch_in];
  assign fhd_cur = fhd_q[ch_q];
  assign lhd_cur = lhd_q[ch_q];

  always_comb begin
    fsum = (TW+1)'(fhd_cur) + (TW+1)'(FIR_TAPS) - (TW+1)'(cmd_i.k);
    if (fsum >= (TW+1)'(FIR_TAPS)) begin
      fsum = fsum - (TW+1)'(FIR_TAPS);
    end
    lsum = (TW+1)'(lhd_cur) + (TW+1)'(LMS_TAPS) - (TW+1)'(cmd_i.k);
    if (lsum >= (TW+1)'(LMS_TAPS)) begin
      lsum = lsum - (TW+1)'(LMS_TAPS);
    end
  end
  assign fidx = FHW'(fsum);
  assign lidx = LHW'(lsum);

  assign fir_we    = cmd_i.accept && !sts_o.skip;
  assign fir_waddr = FAW'(int'(ch_in) * FIR_TAPS + int'(fhd_in));
  assign fir_raddr = FAW'(int'(ch_q) * FIR_TAPS + int'(fidx));
  assign lh_we     = cmd_i.finx;
  assign lh_waddr  = LAW'(int'(ch_q) * LMS_TAPS + int'(lhd_cur));
  assign lh_raddr  = LAW'(int'(ch_q) * LMS_TAPS + int'(lidx));
  assign w_raddr   = LAW'(int'(ch_q) * LMS_TAPS + int'(cmd_i.k));
  assign w_waddr   = LAW'(int'(ch_q) * LMS_TAPS + int'(k2_q));
  assign w_we      = iss2_q && (op2_q == mfl_pkg::OP_UPD);

  mfl_ram #(.WIDTH(16), .DEPTH(FD)) u_fir_ram (
    .clk_i   (clk_i),
    .we_i    (fir_we),
    .waddr_i (fir_waddr),
    .wdata_i (in_raw_i),
    .raddr_i (fir_raddr),
    .rdata_o (fir_rdata)
  );

  mfl_ram #(.WIDTH(16), .DEPTH(LD)) u_lh_ram (
    .clk_i   (clk_i),
    .we_i    (lh_we),
    .waddr_i (lh_waddr),
    .wdata_i (x_new),
    .raddr_i (lh_raddr),
    .rdata_o (lh_rdata)
  );

  mfl_ram #(.WIDTH(24), .DEPTH(LD)) u_w_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  assign fir_d = fv1_q ? $signed(fir_rdata) : 16'sd0;
  assign u_d   = lv1_q ? $signed(lh_rdata) : 16'sd0;
  assign w_d   = wv1_q ? $signed(w_rdata) : 24'sd0;
  assign e     = 17'(x_q) - 17'(y_q);

  always_comb begin
    ma = {{17{u_d[15]}}, u_d};
    mb = {w_d[23], w_d};
    case (op1_q)
      mfl_pkg::OP_FIR: begin
        ma = {{17{fir_d[15]}}, fir_d};
        mb = {{9{coef1_q[15]}}, coef1_q};
      end
      mfl_pkg::OP_LMS: begin
        ma = {{17{u_d[15]}}, u_d};
        mb = {w_d[23], w_d};
      end
      mfl_pkg::OP_MUE: begin
        ma = $signed({17'd0, mu_q});
        mb = {{8{e[16]}}, e};
      end
      mfl_pkg::OP_UPD: begin
        ma = mue_q;
        mb = {{9{u_d[15]}}, u_d};
      end
      mfl_pkg::OP_YY: begin
        ma = {{17{y_q[15]}}, y_q};
        mb = {{9{y_q[15]}}, y_q};
      end
      mfl_pkg::OP_PW: begin
        ma = $signed({1'b0, pwr_q[ch_q]});
        mb = $signed(mfl_pkg::PWR_KEEP);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end
  assign prod_d = ma * mb;

  always_comb begin
    rx = (acc_q + ACCW'(16384)) >>> 15;
    if (rx > 48'sd32767) begin
      x_new = 16'sh7fff;
    end else if (rx < -48'sd32768) begin
      x_new = -16'sh8000;
    end else begin
      x_new = rx[15:0];
    end
    ry = (acc_q + ACCW'(524288)) >>> 20;
    if (ry > 48'sd32767) begin
      y_new = 16'sh7fff;
    end else if (ry < -48'sd32768) begin
      y_new = -16'sh8000;
    end else begin
      y_new = ry[15:0];
    end
    upd  = (prod_q + 58'sd33554432) >>> 26;
    wsum = {{2{w2_q[23]}}, w2_q} + upd[25:0];
    if (wsum > 26'sd8388607) begin
      w_wdata = 24'h7fffff;
    end else if (wsum < -26'sd8388608) begin
      w_wdata = 24'h800000;
    end else begin
      w_wdata = wsum[23:0];
    end
    psum = {1'b0, prod_q[48:0]} + {13'd0, yy_q, 6'd0} + {18'd0, yy_q, 1'b0} + 50'd32768;
    pnew = (|psum[49:48]) ? {mfl_pkg::PWR_W{1'b1}} : psum[47:16];
  end

  always_ff @(posedge clk_i) begin
    coef1_q <= mfl_pkg::lp_coef(cmd_i.k);
    prod_q  <= prod_d;
    w2_q    <= w_d;
    k1_q    <= cmd_i.k;
    k2_q    <= k1_q;
    if (cmd_i.accept) begin
      ch_q  <= ch_in;
      raw_q <= $signed(in_raw_i);
      rej_q <= rej_in;
      byp_q <= !en_q;
      acc_q <= '0;
    end else if (cmd_i.finx) begin
      x_q   <= x_new;
      acc_q <= '0;
    end else if (iss2_q && (op2_q == mfl_pkg::OP_FIR || op2_q == mfl_pkg::OP_LMS)) begin
      acc_q <= acc_q + prod_q[ACCW-1:0];
    end
    if (cmd_i.finy) begin
      y_q <= y_new;
    end
    if (iss2_q && op2_q == mfl_pkg::OP_MUE) begin
      mue_q <= prod_q[32:0];
    end
    if (iss2_q && op2_q == mfl_pkg::OP_YY) begin
      yy_q <= prod_q[30:0];
    end
    if (cmd_i.finish) begin
      filt_q <= rej_q ? '0 : (byp_q ? raw_q : y_q);
      opwr_q <= rej_q ? '0 : pwr_q[ch_q];
      stat_q <= rej_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= mfl_pkg::ENABLE_RST;
      act_q       <= mfl_pkg::ACTIVE_RST;
      mu_q        <= mfl_pkg::STEP_RST;
      ffull_q     <= '0;
      lfull_q     <= '0;
      wdone_q     <= '0;
      iss1_q      <= 1'b0;
      iss2_q      <= 1'b0;
      op1_q       <= mfl_pkg::OP_FIR;
      op2_q       <= mfl_pkg::OP_FIR;
      fv1_q       <= 1'b0;
      lv1_q       <= 1'b0;
      wv1_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        fhd_q[i] <= '0;
        lhd_q[i] <= '0;
        pwr_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mfl_pkg::CFG_ENABLE: en_q  <= cfg_data_i[0];
          mfl_pkg::CFG_ACTIVE: act_q <= cfg_data_i[mfl_pkg::ACT_W-1:0];
          mfl_pkg::CFG_STEP:   mu_q  <= cfg_data_i[mfl_pkg::MU_W-1:0];
          default: ;
        endcase
      end
      iss1_q <= cmd_i.issue;
      iss2_q <= iss1_q;
      op1_q  <= cmd_i.op;
      op2_q  <= op1_q;
      // History entries fill in ring order from zero, so an entry holds data
      // once the ring has wrapped or the entry is at or below the head.
      fv1_q  <= ffull_q[ch_q] || (fidx <= fhd_cur);
      lv1_q  <= lfull_q[ch_q] || (lidx <= lhd_cur);
      wv1_q  <= wdone_q[ch_q];
      if (iss2_q && op2_q == mfl_pkg::OP_PW) begin
        pwr_q[ch_q] <= pnew;
      end
      if (cmd_i.finish && !rej_q && !byp_q) begin
        fhd_q[ch_q] <= (fhd_cur == FHW'(FIR_TAPS - 1)) ? '0 : fhd_cur + 1'b1;
        lhd_q[ch_q] <= (lhd_cur == LHW'(LMS_TAPS - 1)) ? '0 : lhd_cur + 1'b1;
        wdone_q[ch_q] <= 1'b1;
        if (fhd_cur == FHW'(FIR_TAPS - 1)) begin
          ffull_q[ch_q] <= 1'b1;
        end
        if (lhd_cur == LHW'(LMS_TAPS - 1)) begin
          lfull_q[ch_q] <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_filt_o   = filt_q;
  assign out_pwr_o    = opwr_q;
  assign out_status_o = stat_q;

endmodule

// ===== hdl/multichannel_fir_lms_sample_filter.sv =====
// Per-channel sensor filter: each sample runs through a fixed low-pass FIR, then an LMS
// adaptive filter whose desired signal is the FIR output, and the channel's output power
// is tracked as a running average. One item is processed at a time on a single shared
// multiplier, one tap per cycle: an accepted sample runs through the FIR, the LMS filter,
// the weight update and the power update before its result is offered, while a rejected
// channel or a sample in bypass mode skips them. A finished result sits in an
// output register, so the next sample is taken while it waits. Channel state is cleared
// by reset; no configuration write is needed before the first sample.
module multichannel_fir_lms_sample_filter #(
  parameter int CHANNELS = mfl_pkg::CHANNELS_DEF,
  parameter int FIR_TAPS = mfl_pkg::FIR_TAPS_DEF,
  parameter int LMS_TAPS = mfl_pkg::LMS_TAPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mfl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mfl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mfl_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // raw_sample
  input  logic [mfl_pkg::S_TUSER_W-1:0]  s_axis_tuser,   // channel_sel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mfl_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // filtered_sample, channel_power
  output logic [mfl_pkg::M_TUSER_W-1:0]  m_axis_tuser    // status
);

  mfl_pkg::mfl_cmd_t cmd;
  mfl_pkg::mfl_sts_t sts;
  logic [mfl_pkg::SMP_W-1:0] filt;
  logic [mfl_pkg::PWR_W-1:0] pwr;
  logic                      stat;

  mfl_ctrl #(
    .FIR_TAPS (FIR_TAPS),
    .LMS_TAPS (LMS_TAPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mfl_dp #(
    .CHANNELS (CHANNELS),
    .FIR_TAPS (FIR_TAPS),
    .LMS_TAPS (LMS_TAPS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_ch_i      (s_axis_tuser),
    .in_raw_i     (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_filt_o   (filt),
    .out_pwr_o    (pwr),
    .out_status_o (stat)
  );

  assign m_axis_tdata = {pwr, filt};
  assign m_axis_tuser = stat;

endmodule

// ===== hdl/mfl_checker.sv =====
module mfl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mfl_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [mfl_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  // A rejected channel carries no sample and no power.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("rejected result carries data");

  // Only one sample is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a sample is in work");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind multichannel_fir_lms_sample_filter mfl_checker u_mfl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
